### hw/rtl/heightfield_bilinear_sampler_top_defines.svh
// Assertion macros shared by the sampler RTL.
`ifndef HEIGHTFIELD_BILINEAR_SAMPLER_TOP_DEFINES_SVH
`define HEIGHTFIELD_BILINEAR_SAMPLER_TOP_DEFINES_SVH
// Implication checked on every clock, off during reset.
`define HBS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, off during reset.
`define HBS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hw/rtl/hbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_pkg
// Types and constants for the heightfield bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;
  localparam int DEF_MAX_COLS    = 256;
  localparam int DEF_MAX_ROWS    = 256;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SWAP   = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] REG_COLS    = 3'd0;
  localparam logic [2:0] REG_ROWS    = 3'd1;
  localparam logic [2:0] REG_WIDTH   = 3'd2;
  localparam logic [2:0] REG_DEFAULT = 3'd3;
  localparam logic [2:0] REG_CX      = 3'd4;
  localparam logic [2:0] REG_CY      = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIVX, ST_DIVY, ST_GRID, ST_ADDR, ST_READ,
    ST_LERP, ST_OUT
  } state_t;
endpackage

### hw/rtl/heightfield_bilinear_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_bilinear_sampler_top
// Double-buffered sample grid with bilinear sampling of the front buffer.
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// in_     | in  | in_valid/in_ready    | opcode, cell, samples, query x/y
// out_    | out | out_valid/out_ready  | height_cm, vel, acc, fallback
// cfg_    | in  | cfg_we               | cfg_index, cfg_data
// A query runs two 49-step restoring divisions that share one subtractor, then grid
// mapping, 4 corner indexes, 4 corner reads, 21 passes of the lerp unit and the output
// state. A fallback query answers the next cycle. After reset a clearing pass zeroes
// all 2*MAX_COLS*MAX_ROWS memory words; no input is taken until it ends.
// The result waits in a register until transferred; no new item is taken meanwhile.
`include "heightfield_bilinear_sampler_top_defines.svh"
module heightfield_bilinear_sampler_top
  import hbs_pkg::*;
#(
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [15:0]        in_cell_index,
  input  logic signed [15:0] in_height_in,
  input  logic signed [15:0] in_vel_x_in,
  input  logic signed [15:0] in_vel_y_in,
  input  logic signed [15:0] in_vel_z_in,
  input  logic signed [15:0] in_acc_x_in,
  input  logic signed [15:0] in_acc_y_in,
  input  logic signed [15:0] in_acc_z_in,
  input  logic signed [31:0] in_query_x,
  input  logic signed [31:0] in_query_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [22:0] out_height_cm,
  output logic signed [15:0] out_vel_x,
  output logic signed [15:0] out_vel_y,
  output logic signed [15:0] out_vel_z,
  output logic signed [15:0] out_acc_x,
  output logic signed [15:0] out_acc_y,
  output logic signed [15:0] out_acc_z,
  output logic               out_fallback,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int CW    = $clog2(CELLS);
  localparam int AW    = CW + 1;
  localparam int SB    = SAMPLE_BITS;
  localparam int WORDW = 7 * SB;
  localparam int DIVN  = 49;

  // configuration
  logic [8:0]         cols_r, rows_r;
  logic [23:0]        width_r;
  logic signed [22:0] deflt_r;
  logic signed [31:0] cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= 9'd256;
      rows_r  <= 9'd256;
      width_r <= 24'd100000;
      deflt_r <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLS:    cols_r  <= cfg_data[8:0];
        REG_ROWS:    rows_r  <= cfg_data[8:0];
        REG_WIDTH:   width_r <= cfg_data[23:0];
        REG_DEFAULT: deflt_r <= cfg_data[22:0];
        REG_CX:      cx_r    <= cfg_data;
        REG_CY:      cy_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample memory: one word holds all seven samples of a cell
  logic [WORDW-1:0] mem [2*CELLS];
  logic [WORDW-1:0] rd_r;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [WORDW-1:0] mem_wd;
  logic [AW-1:0]    mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[mem_ra];
  end

  state_t state_r, state_nxt;
  logic          front_r, front_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  // division: num = (2*local + W)*2^15, quotient floor over W, clamped
  logic signed [34:0] loc_y_r, loc_y_nxt;   // 2*local+W for Y, kept for 2nd pass
  logic        neg_r, neg_nxt;
  logic [49:0] rem_r, rem_nxt;              // remainder, shifted dividend
  logic [33:0] num_r, num_nxt;              // |2*local+W|
  logic [48:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [16:0] u_r, u_nxt, v_r, v_nxt;

  // grid
  logic [15:0] fxf_r, fxf_nxt, fyf_r, fyf_nxt;
  logic [8:0]  x0_r, x1_r, y0_r, y1_r, x0_nxt, x1_nxt, y0_nxt, y1_nxt;
  logic [17:0] idx_r [4];
  logic [17:0] idx_nxt [4];
  logic [1:0]  cor_r, cor_nxt;
  logic        rdv_r, rdv_nxt;
  logic [1:0]  rdc_r, rdc_nxt;
  logic signed [23:0] cv_r [4][7];
  logic signed [23:0] cv_nxt [4][7];
  logic signed [23:0] top_r, top_nxt, bot_r, bot_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic signed [22:0] oh_r, oh_nxt;
  logic signed [15:0] ov_r [6];
  logic signed [15:0] ov_nxt [6];
  logic        ovalid_r, ovalid_nxt, ofb_r, ofb_nxt;

  // shared lerp unit: (a*(65536-f) + b*f + 32768) >>> 16
  logic signed [23:0] la, lb;
  logic [15:0]        lf;
  logic signed [41:0] lsum;
  logic signed [23:0] lres;
  always_comb begin
    lsum = 42'(la) * $signed({1'b0, 17'(17'h10000 - {1'b0, lf})})
         + 42'(lb) * $signed({1'b0, lf}) + 42'sd32768;
    lres = 24'(lsum >>> 16);
  end

  logic signed [34:0] lx_full, ly_full;
  assign lx_full = 35'(({{3{in_query_x[31]}}, in_query_x} - {{3{cx_r[31]}}, cx_r}) * 2)
                 + 35'({1'b0, width_r});
  assign ly_full = 35'(({{3{in_query_y[31]}}, in_query_y} - {{3{cy_r[31]}}, cy_r}) * 2)
                 + 35'({1'b0, width_r});

  logic        fb;
  assign fb = (cols_r <= 9'd1) || (rows_r <= 9'd1) || (width_r == 24'd0);

  function automatic logic [16:0] clampq(input logic n, input logic [48:0] q,
                                         input logic rz);
    logic [49:0] fq;
    begin
      fq = n ? (50'(q) + 50'(rz)) : 50'(q);
      if (n) clampq = (fq == 50'd0) ? 17'd0 : 17'd0;
      else   clampq = (fq > 50'd65536) ? 17'h10000 : fq[16:0];
    end
  endfunction

  function automatic logic signed [23:0] sxs(input logic [SB-1:0] s);
    sxs = 24'($signed(s));
  endfunction

  logic [25:0] gx, gy;
  logic [17:0] ilin;
  logic        ioob;

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    clr_nxt    = clr_r;
    loc_y_nxt  = loc_y_r;
    neg_nxt    = neg_r;
    rem_nxt    = rem_r;
    num_nxt    = num_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    u_nxt      = u_r;
    v_nxt      = v_r;
    fxf_nxt    = fxf_r;
    fyf_nxt    = fyf_r;
    x0_nxt     = x0_r; x1_nxt = x1_r; y0_nxt = y0_r; y1_nxt = y1_r;
    idx_nxt    = idx_r;
    cor_nxt    = cor_r;
    rdv_nxt    = 1'b0;
    rdc_nxt    = cor_r;
    cv_nxt     = cv_r;
    top_nxt    = top_r;
    bot_nxt    = bot_r;
    k_nxt      = k_r;
    ph_nxt     = ph_r;
    oh_nxt     = oh_r;
    ov_nxt     = ov_r;
    ovalid_nxt = ovalid_r;
    ofb_nxt    = ofb_r;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = clr_r;
    mem_wd     = '0;
    mem_ra     = '0;
    la = top_r; lb = bot_r; lf = fyf_r;
    gx = 26'(u_r) * 26'(cols_r - 9'd1);
    gy = 26'(v_r) * 26'(rows_r - 9'd1);
    ilin = 18'(y0_r) * 18'(cols_r) + 18'(x0_r);
    ioob = 1'b0;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(2*CELLS-1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = !ovalid_r;
        if (in_valid && in_ready) begin
          unique case (in_opcode)
            OP_WRITE: begin
              if (32'(in_cell_index) < 32'(CELLS)) begin
                mem_we = 1'b1;
                mem_wa = {~front_r, CW'(in_cell_index)};
                mem_wd = {SB'(in_acc_z_in), SB'(in_acc_y_in),
                          SB'(in_acc_x_in), SB'(in_vel_z_in),
                          SB'(in_vel_y_in), SB'(in_vel_x_in),
                          SB'(in_height_in)};
              end
            end
            OP_SWAP: front_nxt = ~front_r;
            OP_QUERY: begin
              if (fb) begin
                ovalid_nxt = 1'b1;
                ofb_nxt    = 1'b1;
                oh_nxt     = deflt_r;
                for (int i = 0; i < 6; i++) ov_nxt[i] = '0;
              end else begin
                neg_nxt   = lx_full[34];
                num_nxt   = lx_full[34] ? 34'(-lx_full) : lx_full[33:0];
                loc_y_nxt = ly_full;
                rem_nxt   = {25'd0, lx_full[34] ? 25'(34'(-lx_full) >> 9)
                                               : 25'(lx_full[33:9])};
                rem_nxt   = '0;
                quo_nxt   = '0;
                cnt_nxt   = '0;
                state_nxt = ST_DIVX;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIVX, ST_DIVY: begin
        // restoring division of num*2^15 by W, one quotient bit a cycle
        begin
          logic [49:0] dv;
          logic [25:0] pr;
          logic        bit_in;
          logic [25:0] t;
          dv     = {num_r, 16'd0} >> 1;
          bit_in = dv[6'd48 - cnt_r];
          pr     = {rem_r[48:24], bit_in};
          t      = pr - {2'b0, width_r};
          if (!t[25]) begin
            rem_nxt[49:24] = t;
            quo_nxt = {quo_r[47:0], 1'b1};
          end else begin
            rem_nxt[49:24] = pr;
            quo_nxt = {quo_r[47:0], 1'b0};
          end
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == 6'(DIVN - 1)) begin
            if (state_r == ST_DIVX) begin
              u_nxt     = clampq(neg_r, quo_nxt, rem_nxt[49:24] != 26'd0);
              neg_nxt   = loc_y_r[34];
              num_nxt   = loc_y_r[34] ? 34'(-loc_y_r) : loc_y_r[33:0];
              rem_nxt   = '0;
              quo_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ST_DIVY;
            end else begin
              v_nxt     = clampq(neg_r, quo_nxt, rem_nxt[49:24] != 26'd0);
              state_nxt = ST_GRID;
            end
          end
        end
      end
      ST_GRID: begin
        x0_nxt  = gx[24:16];
        y0_nxt  = gy[24:16];
        fxf_nxt = gx[15:0];
        fyf_nxt = gy[15:0];
        x1_nxt  = (gx[24:16] + 9'd1 < cols_r - 9'd1) ? gx[24:16] + 9'd1 : cols_r - 9'd1;
        y1_nxt  = (gy[24:16] + 9'd1 < rows_r - 9'd1) ? gy[24:16] + 9'd1 : rows_r - 9'd1;
        cor_nxt = '0;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        // one corner index per cycle through the shared multiplier
        ilin = 18'(cor_r[1] ? y1_r : y0_r) * 18'(cols_r)
             + 18'(cor_r[0] ? x1_r : x0_r);
        idx_nxt[cor_r] = ilin;
        cor_nxt = cor_r + 1'b1;
        if (cor_r == 2'd3) begin
          cor_nxt   = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (!rdv_r || cor_r != 2'd0 || rdc_r != 2'd3) begin
          mem_ra  = {front_r, CW'(idx_r[cor_r])};
          rdv_nxt = 1'b1;
          rdc_nxt = cor_r;
          cor_nxt = cor_r + 1'b1;
        end
        if (rdv_r) begin
          ioob = 32'(idx_r[rdc_r]) >= 32'(CELLS);
          for (int j = 0; j < 7; j++) begin
            if (ioob) cv_nxt[rdc_r][j] = (j == 0) ? 24'(deflt_r) : '0;
            else if (j == 0) cv_nxt[rdc_r][j] = sxs(rd_r[SB-1:0]) * 24'sd100;
            else cv_nxt[rdc_r][j] = sxs(rd_r[j*SB +: SB]);
          end
          if (rdc_r == 2'd3) begin
            rdv_nxt   = 1'b0;
            k_nxt     = '0;
            ph_nxt    = '0;
            state_nxt = ST_LERP;
          end
        end
      end
      ST_LERP: begin
        unique case (ph_r)
          2'd0: begin la = cv_r[0][k_r]; lb = cv_r[1][k_r]; lf = fxf_r; top_nxt = lres; end
          2'd1: begin la = cv_r[2][k_r]; lb = cv_r[3][k_r]; lf = fxf_r; bot_nxt = lres; end
          default: begin la = top_r; lb = bot_r; lf = fyf_r; end
        endcase
        ph_nxt = ph_r + 1'b1;
        if (ph_r == 2'd2) begin
          ph_nxt = '0;
          if (k_r == 3'd0)
            oh_nxt = (lres > 24'sd4194303) ? 23'sd4194303 :
                     (lres < -24'sd4194304) ? -23'sd4194304 : 23'(lres);
          else
            ov_nxt[k_r - 3'd1] = (lres > 24'sd32767) ? 16'sd32767 :
                                 (lres < -24'sd32768) ? -16'sd32768 : 16'(lres);
          k_nxt = k_r + 1'b1;
          if (k_r == 3'd6) state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        ovalid_nxt = 1'b1;
        ofb_nxt    = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      front_r  <= 1'b0;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
      rdv_r    <= 1'b0;
      cnt_r    <= '0;
      cor_r    <= '0;
      k_r      <= '0;
      ph_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
      rdv_r    <= rdv_nxt;
      cnt_r    <= cnt_nxt;
      cor_r    <= cor_nxt;
      k_r      <= k_nxt;
      ph_r     <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    loc_y_r <= loc_y_nxt;
    neg_r   <= neg_nxt;
    rem_r   <= rem_nxt;
    num_r   <= num_nxt;
    quo_r   <= quo_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    fxf_r   <= fxf_nxt;
    fyf_r   <= fyf_nxt;
    x0_r    <= x0_nxt; x1_r <= x1_nxt; y0_r <= y0_nxt; y1_r <= y1_nxt;
    idx_r   <= idx_nxt;
    rdc_r   <= rdc_nxt;
    cv_r    <= cv_nxt;
    top_r   <= top_nxt;
    bot_r   <= bot_nxt;
    oh_r    <= oh_nxt;
    ov_r    <= ov_nxt;
    ofb_r   <= ofb_nxt;
  end

  assign out_valid     = ovalid_r;
  assign out_height_cm = oh_r;
  assign out_vel_x     = ov_r[0];
  assign out_vel_y     = ov_r[1];
  assign out_vel_z     = ov_r[2];
  assign out_acc_x     = ov_r[3];
  assign out_acc_y     = ov_r[4];
  assign out_acc_z     = ov_r[5];
  assign out_fallback  = ofb_r;

  `HBS_ASSERT_IMP(a_ready_idle, in_ready, state_r == ST_IDLE && !ovalid_r)
  `HBS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_height_cm))
  `HBS_ASSERT_IMP(a_fb_vec, out_valid && out_fallback, out_vel_x == 16'sd0 && out_acc_z == 16'sd0)
  `HBS_ASSERT_NXT(a_swap, in_valid && in_ready && in_opcode == OP_SWAP, front_r != $past(front_r))
endmodule

### test/hbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_checker
// Watches the item, result and register ports of the heightfield sampler,
// keeps its own copy of both sample buffers and the settings, predicts each
// query answer and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module hbs_checker
  import hbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [15:0]        in_cell_index,
  input  logic signed [15:0] in_height_in,
  input  logic signed [15:0] in_vel_x_in,
  input  logic signed [15:0] in_vel_y_in,
  input  logic signed [15:0] in_vel_z_in,
  input  logic signed [15:0] in_acc_x_in,
  input  logic signed [15:0] in_acc_y_in,
  input  logic signed [15:0] in_acc_z_in,
  input  logic signed [31:0] in_query_x,
  input  logic signed [31:0] in_query_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [22:0] out_height_cm,
  input  logic signed [15:0] out_vel_x,
  input  logic signed [15:0] out_vel_y,
  input  logic signed [15:0] out_vel_z,
  input  logic signed [15:0] out_acc_x,
  input  logic signed [15:0] out_acc_y,
  input  logic signed [15:0] out_acc_z,
  input  logic               out_fallback,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  localparam int CELLS = DEF_MAX_COLS * DEF_MAX_ROWS;

  typedef struct packed {
    logic signed [22:0] hcm;
    logic [5:0][15:0]   vec;   // vel x,y,z then acc x,y,z
    logic               fb;
  } sample_t;

  // per cell: height, vel x/y/z, acc x/y/z
  logic signed [15:0] grid_mem [0:2*CELLS-1][0:6];
  logic    front;
  longint  cols, rows, width, def_lvl, cx, cy;
  sample_t answers [$];

  initial begin
    for (int i = 0; i < 2 * CELLS; i++)
      for (int k = 0; k < 7; k++) grid_mem[i][k] = '0;
  end

  function automatic longint fdiv(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return (a * (65536 - f) + b * f + 32768) >>> 16;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint norm_pos(longint q, longint c);
    longint u;
    u = fdiv((2 * (q - c) + width) * 32768, width);
    if (u < 0) u = 0;
    if (u > 65536) u = 65536;
    return u;
  endfunction

  function automatic longint corner(longint idx, int k);
    longint base;
    base = front ? CELLS : 0;
    if (idx >= CELLS) return (k == 0) ? def_lvl : 0;
    if (k == 0) return longint'(grid_mem[base + idx][0]) * 100;
    return longint'(grid_mem[base + idx][k]);
  endfunction

  function automatic sample_t predict_query(longint qx, longint qy);
    sample_t s;
    longint gx, gy, x0, y0, x1, y1, fx, fy, top, bot, r;
    s = '0;
    if (cols <= 1 || rows <= 1 || width == 0) begin
      s.hcm = def_lvl[22:0];
      s.fb = 1'b1;
      return s;
    end
    gx = norm_pos(qx, cx) * (cols - 1);
    gy = norm_pos(qy, cy) * (rows - 1);
    x0 = gx >> 16;
    y0 = gy >> 16;
    fx = gx & 16'hFFFF;
    fy = gy & 16'hFFFF;
    x1 = (x0 + 1 < cols - 1) ? x0 + 1 : cols - 1;
    y1 = (y0 + 1 < rows - 1) ? y0 + 1 : rows - 1;
    for (int k = 0; k < 7; k++) begin
      top = blend(corner(y0 * cols + x0, k), corner(y0 * cols + x1, k), fx);
      bot = blend(corner(y1 * cols + x0, k), corner(y1 * cols + x1, k), fx);
      r = blend(top, bot, fy);
      if (k == 0) s.hcm = 23'(clip(r, 23));
      else s.vec[k-1] = 16'(clip(r, 16));
    end
    return s;
  endfunction

  always @(posedge clk) begin
    sample_t got, want;
    longint back;
    if (!rst_n) begin
      front <= 1'b0;
      fail_count <= 0;
      cols <= 256; rows <= 256; width <= 100000;
      def_lvl <= 0; cx <= 0; cy <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COLS:    cols <= longint'(cfg_data[8:0]);
          REG_ROWS:    rows <= longint'(cfg_data[8:0]);
          REG_WIDTH:   width <= longint'(cfg_data[23:0]);
          REG_DEFAULT: def_lvl <= longint'($signed(cfg_data[22:0]));
          REG_CX:      cx <= longint'($signed(cfg_data));
          REG_CY:      cy <= longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_opcode)
          OP_WRITE: begin
            back = front ? 0 : CELLS;
            grid_mem[back + in_cell_index][0] <= in_height_in;
            grid_mem[back + in_cell_index][1] <= in_vel_x_in;
            grid_mem[back + in_cell_index][2] <= in_vel_y_in;
            grid_mem[back + in_cell_index][3] <= in_vel_z_in;
            grid_mem[back + in_cell_index][4] <= in_acc_x_in;
            grid_mem[back + in_cell_index][5] <= in_acc_y_in;
            grid_mem[back + in_cell_index][6] <= in_acc_z_in;
          end
          OP_SWAP:  front <= ~front;
          OP_QUERY: answers.push_back(predict_query(in_query_x, in_query_y));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.hcm = out_height_cm;
        got.vec = {out_acc_z, out_acc_y, out_acc_x, out_vel_z, out_vel_y, out_vel_x};
        got.fb = out_fallback;
        if (answers.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("result transfer with nothing expected");
        end else begin
          want = answers.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp h=%0d v=%h fb=%b, got h=%0d v=%h fb=%b",
                       want.hcm, want.vec, want.fb, got.hcm, got.vec, got.fb);
          end
        end
      end
    end
    pending <= answers.size();
  end
endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Heightfield sampler test: directed corner queries on the reset grid, then
// random writes, swaps, queries and unused opcodes over several grid settings,
// with random gaps on both channels. The checker module judges every result.
// ----------------------------------------------------------------------------
module testbench;
  import hbs_pkg::*;

  logic               clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  logic [1:0]         in_opcode;
  logic [15:0]        in_cell_index;
  logic signed [15:0] in_height_in, in_vel_x_in, in_vel_y_in, in_vel_z_in;
  logic signed [15:0] in_acc_x_in, in_acc_y_in, in_acc_z_in;
  logic signed [31:0] in_query_x, in_query_y;
  logic signed [22:0] out_height_cm;
  logic signed [15:0] out_vel_x, out_vel_y, out_vel_z, out_acc_x, out_acc_y, out_acc_z;
  logic               out_fallback, cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 fail_count, pending;
  logic               no_gaps;
  int                 ready_hold;
  longint             cols_now, rows_now, width_now, cx_now, cy_now;

  heightfield_bilinear_sampler_top uut (.*);
  hbs_checker chk (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  initial begin
    #30ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
    end else if (out_valid && out_ready) begin
      w = no_gaps ? 0 : $urandom_range(0, 4);
      ready_hold <= w;
      out_ready <= (w == 0);
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= (ready_hold == 1);
    end else out_ready <= 1'b1;
  end

  task automatic send(logic [1:0] op, logic [15:0] idx, logic [6:0][15:0] smp,
                      logic [31:0] qx, logic [31:0] qy);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_cell_index <= idx;
    {in_acc_z_in, in_acc_y_in, in_acc_x_in, in_vel_z_in, in_vel_y_in, in_vel_x_in,
     in_height_in} <= smp;
    in_query_x <= qx;
    in_query_y <= qy;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_grid(longint c, longint r, longint w, longint dl,
                          longint x, longint y);
    logic [31:0] vals [6];
    vals = '{32'(c), 32'(r), 32'(w), 32'(dl), 32'(x), 32'(y)};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cols_now = c; rows_now = r; width_now = w; cx_now = x; cy_now = y;
  endtask

  function automatic logic [6:0][15:0] rand_cell();
    logic [6:0][15:0] s;
    for (int k = 0; k < 7; k++)
      case ($urandom_range(0, 7))
        0: s[k] = 16'h7FFF;
        1: s[k] = 16'h8000;
        default: s[k] = 16'($urandom);
      endcase
    return s;
  endfunction

  function automatic logic [31:0] rand_pos(longint c);
    longint span;
    span = width_now / 2 + width_now / 8 + 1;
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'(c + longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic random_items(int n);
    int r;
    longint cells;
    cells = cols_now * rows_now;
    if (cells < 1) cells = 1;
    if (cells > 65536) cells = 65536;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        send(OP_WRITE, 16'(($urandom_range(0, 4) == 0) ? $urandom : $urandom % cells),
             rand_cell(), $urandom, $urandom);
      else if (r < 50) send(OP_SWAP, 16'($urandom), rand_cell(), $urandom, $urandom);
      else if (r < 96)
        send(OP_QUERY, 16'($urandom), rand_cell(), rand_pos(cx_now), rand_pos(cy_now));
      else send(OP_UNUSED, 16'($urandom), rand_cell(), $urandom, $urandom);
    end
  endtask

  initial begin
    logic [6:0][15:0] hi_cell, lo_cell;
    rst_n = 1'b0; in_valid = 1'b0; in_opcode = OP_WRITE; in_cell_index = '0;
    {in_height_in, in_vel_x_in, in_vel_y_in, in_vel_z_in} = '0;
    {in_acc_x_in, in_acc_y_in, in_acc_z_in, in_query_x, in_query_y} = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    no_gaps = 1'b0;
    cols_now = 256; rows_now = 256; width_now = 100000; cx_now = 0; cy_now = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    hi_cell = {7{16'h7FFF}};
    lo_cell = {7{16'h8000}};

    // reset grid: empty query, extreme cells at both corners, clamped positions
    send(OP_QUERY, 0, '0, 32'd0, 32'd0);
    send(OP_WRITE, 16'd0, hi_cell, 0, 0);
    send(OP_WRITE, 16'd1, lo_cell, 0, 0);
    send(OP_WRITE, 16'd256, lo_cell, 0, 0);
    send(OP_WRITE, 16'hFFFF, lo_cell, 0, 0);
    send(OP_WRITE, 16'hFFFE, hi_cell, 0, 0);
    send(OP_QUERY, 0, '0, -32'sd50000, -32'sd50000);
    send(OP_SWAP, 0, '0, 0, 0);
    send(OP_UNUSED, 16'hFFFF, hi_cell, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(OP_QUERY, 0, '0, -32'sd50000, -32'sd50000);
    send(OP_QUERY, 0, '0, 32'sd50000, 32'sd50000);
    send(OP_QUERY, 0, '0, 32'h7FFFFFFF, 32'h80000000);
    send(OP_QUERY, 0, '0, 32'h80000000, 32'h7FFFFFFF);
    send(OP_QUERY, 0, '0, -32'sd49805, -32'sd50000);
    send(OP_QUERY, 0, '0, 32'sd49900, 32'sd49990);
    send(OP_SWAP, 0, '0, 0, 0);
    send(OP_QUERY, 0, '0, 32'sd50000, 32'sd50000);
    drain();

    no_gaps = 1'b1;
    set_grid(4, 3, 1000, -3276800, 0, 0);
    random_items(200);
    drain();
    no_gaps = 1'b0;
    set_grid(2, 2, 16777215, 3276800, 32'h7FFFFFFF, 32'h80000000);
    random_items(200);
    drain();
    set_grid(16, 9, 37, 12345, -500, 700);
    random_items(250);
    drain();
    set_grid(0, 5, 1000, -100, 3, -3);
    random_items(60);
    drain();
    set_grid(6, 6, 0, 777, 0, 0);
    random_items(60);
    drain();
    set_grid(1, 256, 5000, 3276800, 0, 0);
    random_items(60);
    drain();
    set_grid(511, 511, 100000, -3276800, -20000, 20000);
    random_items(250);
    drain();
    set_grid(256, 256, 65536, 0, $urandom, $urandom);
    random_items(250);
    drain();
    set_grid(8, 8, 640, 256, 100, -100);
    random_items(350);
    drain();

    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
